// ----- rtl/extended_to_double_convert_unit_assert.svh -----
// assertion macros for the extended to double conversion unit
`ifndef EXTENDED_TO_DOUBLE_CONVERT_UNIT_ASSERT_SVH
`define EXTENDED_TO_DOUBLE_CONVERT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ETD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ETD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ETD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ETD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/etd_pkg.sv -----
package etd_pkg;
  localparam logic [2:0] CLS_INF      = 3'd0;
  localparam logic [2:0] CLS_SNAN     = 3'd1;
  localparam logic [2:0] CLS_QNAN     = 3'd2;
  localparam logic [2:0] CLS_NORMAL   = 3'd3;
  localparam logic [2:0] CLS_DENORMAL = 3'd4;
  localparam logic [2:0] CLS_ZERO     = 3'd5;
  localparam logic [2:0] CLS_INVALID  = 3'd6;

  localparam logic [14:0] EXP_ONES    = 15'h7fff;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8000000000000;
  localparam logic [63:0] DBL_INF     = 64'h7FF0000000000000;
  localparam logic [63:0] DBL_QBIT    = 64'h0008000000000000;

  typedef struct packed {
    logic [63:0] ext_significand;
    logic [15:0] ext_sign_exponent;
  } ext_item_t;

  typedef struct packed {
    logic [63:0] double_bits;
    logic [2:0]  value_class;
  } dbl_item_t;
endpackage

// ----- rtl/etd_stream_if.sv -----
interface etd_in_if import etd_pkg::*; ();
  logic      valid;
  logic      ready;
  ext_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface etd_out_if import etd_pkg::*; ();
  logic      valid;
  logic      ready;
  dbl_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/etd_core.sv -----
module etd_core import etd_pkg::*; (
  input  ext_item_t item,
  output dbl_item_t res
);
  logic        sgn;
  logic [14:0] e;
  logic [63:0] sig;
  logic [15:0] d;
  logic [6:0]  sh;
  logic [63:0] q;
  logic [63:0] rem;
  logic [63:0] half;
  logic [63:0] mask;
  logic [63:0] qr;
  logic [63:0] bits;
  logic [2:0]  cls;

  assign sgn = item.ext_sign_exponent[15];
  assign e   = item.ext_sign_exponent[14:0];
  assign sig = item.ext_significand;
  // rebiased exponent, may be negative
  assign d   = {1'b0, e} - 16'd15360;

  // shift amount: 11 for normal range, 12-d below it, 65 when d is below -52
  always_comb begin
    if (!d[15] && d != 16'd0) sh = 7'd11;
    else if ($signed(d) < -16'sd52) sh = 7'd65;
    else sh = 7'(16'd12 - d);
  end

  // shift right with round to nearest even
  always_comb begin
    mask = 64'd0;
    half = 64'd0;
    q    = 64'd0;
    if (sh >= 7'd64) begin
      mask = '1;
      q    = 64'd0;
    end else begin
      mask = (64'd1 << sh[5:0]) - 64'd1;
      q    = sig >> sh[5:0];
    end
    if (sh <= 7'd64) half = 64'd1 << 6'(sh - 7'd1);
    rem = sig & mask;
    qr  = q;
    if (sh > 7'd64) qr = 64'd0;
    else if (rem > half || (rem == half && q[0])) qr = q + 64'd1;
  end

  // classify and assemble
  always_comb begin
    bits = {sgn, 63'd0};
    cls  = CLS_NORMAL;
    if (e == 15'd0) begin
      cls = (sig == 64'd0) ? CLS_ZERO : CLS_DENORMAL;
    end else if (e == EXP_ONES) begin
      if (!sig[63]) begin
        cls  = CLS_INVALID;
        bits = DEFAULT_NAN;
      end else if (!sig[62] && sig[61:0] == 62'd0) begin
        cls  = CLS_INF;
        bits = {sgn, 63'd0} | DBL_INF;
      end else begin
        cls  = sig[62] ? CLS_QNAN : CLS_SNAN;
        bits = {sgn, 63'd0} | DBL_INF | DBL_QBIT | {12'd0, sig[62:11]};
      end
    end else if (!sig[63]) begin
      cls  = CLS_INVALID;
      bits = DEFAULT_NAN;
    end else if (!d[15] && d >= 16'd2047) begin
      bits = {sgn, 63'd0} | DBL_INF;
    end else if (!d[15] && d != 16'd0) begin
      bits = {sgn, 63'd0} | (({53'd0, d[10:0]} - 64'd1) << 52) + qr;
    end else begin
      bits = {sgn, 63'd0} | qr;
    end
    res.double_bits = bits;
    res.value_class = cls;
  end
endmodule

// ----- rtl/extended_to_double_convert_unit.sv -----
// Converts x87 80-bit extended values to IEEE binary64 with round to nearest
// even, and reports the class of each input. One transaction is accepted per
// cycle while the skid stage is empty. When the output is not stalled, a result
// appears in the cycle after its input is accepted, set by the output register
// behind the combinational conversion. A skid stage behind the output register
// takes one more transaction while the output is stalled; only then does the
// input ready drop. Throughput is one transaction per cycle while not stalled.
`include "extended_to_double_convert_unit_assert.svh"
module extended_to_double_convert_unit import etd_pkg::*; (
  input logic clk,
  input logic rst_n,
  etd_in_if.sink    in_ch,
  etd_out_if.source out_ch
);
  dbl_item_t conv;
  dbl_item_t main_r;
  dbl_item_t skid_r;
  logic      main_vld_r;
  logic      skid_vld_r;
  logic      in_acc;
  logic      out_acc;

  etd_core u_core (.item(in_ch.data), .res(conv));

  assign in_ch.ready  = !skid_vld_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;
  assign out_ch.valid = main_vld_r;
  assign out_ch.data  = main_r;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!main_vld_r || out_acc) begin
        if (skid_vld_r) begin
          main_r     <= skid_r;
          main_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          main_r     <= conv;
          main_vld_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_r     <= conv;
        skid_vld_r <= 1'b1;
      end
    end
  end

  `ETD_ASSERT_IMPL(a_skid_needs_main, clk, rst_n, skid_vld_r, main_vld_r)
  `ETD_ASSERT_NEXT(a_acc_gives_valid, clk, rst_n, in_acc, main_vld_r)
  `ETD_ASSERT_NEXT(a_stall_holds, clk, rst_n, main_vld_r && !out_ch.ready, main_vld_r)
endmodule
